### sv/wbt_pkg.sv
// ----------------------------------------------------------------------------
// Wiegand bit transmitter package
// Shared constants, status codes and the structs passed between the input
// stage, the transmit engine and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package wbt_pkg;

    // Longest word that one send request may carry.
    localparam int MAX_BITS = 64;
    localparam int IDX_W    = $clog2(MAX_BITS);

    // Fixed field widths of the stream items.
    localparam int WORD_W   = 64;
    localparam int NBITS_W  = 7;
    localparam int PW_W     = 8;
    localparam int BI_W     = 16;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 2;

    // Packed widths of the tdata buses, rounded up to whole bytes.
    localparam int S_DATA_W = ((WORD_W + NBITS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((4 + STATUS_W + 7) / 8) * 8;

    // Reset values of the timing registers.
    localparam logic [PW_W-1:0] PULSE_WIDTH_RST  = PW_W'(50);
    localparam logic [BI_W-1:0] BIT_INTERVAL_RST = BI_W'(2000);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PULSE_WIDTH  = 1'b0,
        REG_BIT_INTERVAL = 1'b1
    } reg_idx_t;

    // Request kinds carried in s_tuser.
    typedef enum logic [0:0] {
        REQ_TICK = 1'b0,
        REQ_SEND = 1'b1
    } req_t;

    // Status codes returned with each result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    // Configuration write port.
    typedef struct packed {
        logic             wr_en;
        reg_idx_t         index;
        logic [CFG_W-1:0] data;
    } cfg_wr_t;

    // One registered request.
    typedef struct packed {
        req_t               req_type;
        logic [WORD_W-1:0]  word_in;
        logic [NBITS_W-1:0] num_bits;
    } req_item_t;

    // One result item.
    typedef struct packed {
        status_t status;
        logic    done_res;
        logic    busy_res;
        logic    line_one;
        logic    line_zero;
    } result_t;

endpackage

`default_nettype wire

### sv/wbt_in_stage.sv
// ----------------------------------------------------------------------------
// Wiegand bit transmitter input stage
// Registers one request beat and holds it until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wbt_in_stage
    import wbt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire req_item_t s_item,
    output logic           q_valid,
    input  wire logic      q_take,
    output req_item_t      q_item
);

    logic      valid_reg;
    req_item_t item_reg;

    // The register may load when empty or when its beat leaves this cycle.
    assign s_ready = !valid_reg || q_take;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

### sv/wbt_engine.sv
// ----------------------------------------------------------------------------
// Wiegand bit transmitter engine
// Holds the timing registers and the transmit state, and works out the next
// state and the result for one request combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module wbt_engine
    import wbt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_wr_t   cfg,
    input  wire logic      fire,
    input  wire req_item_t item,
    output result_t        result
);

    logic [PW_W-1:0]     pulse_width_reg;
    logic [BI_W-1:0]     bit_interval_reg;

    logic [MAX_BITS-1:0] shift_word_reg,  shift_word_next;
    logic [NBITS_W-1:0]  bits_left_reg,   bits_left_next;
    logic [BI_W-1:0]     interval_reg,    interval_next;
    logic [PW_W-1:0]     pulse_cnt_reg,   pulse_cnt_next;
    logic                running_reg,     running_next;
    logic                pulse_on_reg,    pulse_on_next;
    logic                pulse_val_reg,   pulse_val_next;
    logic                active_reg,      active_next;

    logic                done;
    status_t             status;
    logic                bad_len;
    logic [PW_W-1:0]     pulse_inc;
    logic [BI_W:0]       interval_inc;
    logic [IDX_W-1:0]    bit_idx;

    // Timing register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_width_reg  <= PULSE_WIDTH_RST;
            bit_interval_reg <= BIT_INTERVAL_RST;
        end else if (cfg.wr_en) begin
            case (cfg.index)
                REG_PULSE_WIDTH:  pulse_width_reg  <= cfg.data[PW_W-1:0];
                REG_BIT_INTERVAL: bit_interval_reg <= cfg.data[BI_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state for one request: an accepted send loads the word, a tick first ends
    // the pulse if due and then handles the interval alarm.
    always_comb begin
        shift_word_next = shift_word_reg;
        bits_left_next  = bits_left_reg;
        interval_next   = interval_reg;
        pulse_cnt_next  = pulse_cnt_reg;
        running_next    = running_reg;
        pulse_on_next   = pulse_on_reg;
        pulse_val_next  = pulse_val_reg;
        active_next     = active_reg;
        done            = 1'b0;
        status          = ST_OK;
        bad_len         = (item.num_bits == '0) ||
                          (item.num_bits > NBITS_W'(MAX_BITS));
        pulse_inc       = pulse_cnt_reg + PW_W'(1);
        interval_inc    = {1'b0, interval_reg} + (BI_W+1)'(1);
        bit_idx         = '0;

        if (item.req_type == REQ_SEND) begin
            if (bad_len) begin
                status = ST_BAD_LEN;
            end else if (active_reg) begin
                status = ST_BUSY;
            end else begin
                shift_word_next = item.word_in[MAX_BITS-1:0];
                bits_left_next  = item.num_bits;
                interval_next   = '0;
                pulse_cnt_next  = '0;
                running_next    = 1'b1;
                pulse_on_next   = 1'b0;
                pulse_val_next  = 1'b0;
                active_next     = 1'b1;
            end
        end else begin
            // Pulse end; a zero width acts as one tick.
            if (pulse_on_reg) begin
                pulse_cnt_next = pulse_inc;
                if (pulse_inc >= pulse_width_reg || pulse_inc == '0) begin
                    pulse_on_next  = 1'b0;
                    pulse_cnt_next = '0;
                    if (bits_left_reg != '0) begin
                        bits_left_next = bits_left_reg - NBITS_W'(1);
                    end
                    if (bits_left_next == '0 && active_reg) begin
                        active_next  = 1'b0;
                        running_next = 1'b0;
                        done         = 1'b1;
                    end
                end
            end

            // Interval alarm starts the pulse of the next bit, MSB first.
            if (running_next) begin
                if (interval_inc >= {1'b0, bit_interval_reg}) begin
                    interval_next = '0;
                    if (bits_left_next == '0) begin
                        running_next = 1'b0;
                    end else begin
                        bit_idx = IDX_W'(bits_left_next - NBITS_W'(1));
                        if (bits_left_next == NBITS_W'(1)) begin
                            running_next = 1'b0;
                        end
                        pulse_cnt_next = '0;
                        pulse_on_next  = 1'b1;
                        pulse_val_next = shift_word_reg[bit_idx];
                    end
                end else begin
                    interval_next = interval_inc[BI_W-1:0];
                end
            end
        end
    end

    // Result reflects the state after the request.
    always_comb begin
        result.line_zero = !(pulse_on_next && !pulse_val_next);
        result.line_one  = !(pulse_on_next && pulse_val_next);
        result.busy_res  = active_next;
        result.done_res  = done;
        result.status    = status;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_left_reg <= '0;
            interval_reg  <= '0;
            pulse_cnt_reg <= '0;
            running_reg   <= 1'b0;
            pulse_on_reg  <= 1'b0;
            pulse_val_reg <= 1'b0;
            active_reg    <= 1'b0;
        end else if (fire) begin
            bits_left_reg <= bits_left_next;
            interval_reg  <= interval_next;
            pulse_cnt_reg <= pulse_cnt_next;
            running_reg   <= running_next;
            pulse_on_reg  <= pulse_on_next;
            pulse_val_reg <= pulse_val_next;
            active_reg    <= active_next;
        end
    end

    // Word being sent.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_word_reg <= '0;
        end else if (fire) begin
            shift_word_reg <= shift_word_next;
        end
    end

endmodule

`default_nettype wire

### sv/wbt_out_stage.sv
// ----------------------------------------------------------------------------
// Wiegand bit transmitter result stage
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wbt_out_stage
    import wbt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    output logic         can_load,
    input  wire result_t result,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    valid_reg;
    result_t result_reg;

    // A new result may enter when the register is empty or drains now.
    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    // Payload, no reset needed.
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

### sv/wiegand_bit_transmitter_top.sv
// ----------------------------------------------------------------------------
// Wiegand bit transmitter top level
// Takes one tick or send request per beat, returns one result per beat.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one result beat. A send (tuser high)
// loads a word of 1 to 64 bits that goes out MSB first; each tick beat
// (tuser low) advances the bit interval and pulse counters by one. The
// block takes one beat per clock cycle while the result side is not
// stalled. A request waits in the request register, the engine works out
// the whole state update combinationally, and the result is loaded into
// the result register when that register has room. Rejected sends report
// status busy or bad length and leave the state alone. The user must write
// timing registers only while no beats are in flight; the block itself
// does not enforce this.
`default_nettype none

module wiegand_bit_transmitter_top
    import wbt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration write port.
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    // Request channel.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [63:0] word_in, [70:64] num_bits, [71] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                s_tuser,
    // Result channel.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [0] line_zero, [1] line_one, [2] busy_res, [3] done_res,
    // [5:4] status, [7:6] zero
    output logic [M_DATA_W-1:0]      m_tdata
);

    cfg_wr_t   cfg;
    req_item_t s_item;
    req_item_t q_item;
    logic      q_valid;
    logic      can_load;
    logic      fire;
    result_t   result;
    result_t   m_result;

    // Unpack the request beat and the configuration write.
    assign s_item.req_type = req_t'(s_tuser);
    assign s_item.word_in  = s_tdata[WORD_W-1:0];
    assign s_item.num_bits = s_tdata[WORD_W +: NBITS_W];
    assign cfg.wr_en       = cfg_wr_en;
    assign cfg.index       = reg_idx_t'(cfg_index);
    assign cfg.data        = cfg_wdata;

    // A request is processed when its result has room.
    assign fire = q_valid && can_load;

    wbt_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (can_load),
        .q_item  (q_item)
    );

    wbt_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (q_item),
        .result  (result)
    );

    wbt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .can_load (can_load),
        .result   (result),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    // Pack the result beat.
    assign m_tdata = {{(M_DATA_W-4-STATUS_W){1'b0}}, m_result.status,
                      m_result.done_res, m_result.busy_res,
                      m_result.line_one, m_result.line_zero};

endmodule

`default_nettype wire

### verif/wiegand_bit_transmitter_top_tb.sv
// ----------------------------------------------------------------------------
// Wiegand bit transmitter testbench
// Drives tick and send beats into the request stream and predicts, beat by
// beat, the D0/D1 levels, busy, done and status. Every result beat is checked
// against the oldest prediction. Directed tests cover bad lengths, busy sends,
// the shortest timing, a bit interval shorter than the pulse, and limits that
// are lowered in the middle of a transmission. Random traffic follows.
// ----------------------------------------------------------------------------

module wiegand_bit_transmitter_top_tb;
    import wbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    reg_idx_t            cfg_index = REG_PULSE_WIDTH;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    req_t                s_tuser   = REQ_TICK;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Random stalls on both sides are enabled while this is set.
    bit stall_en = 1'b1;

    // Predicted line results, oldest first.
    result_t expected_lines[$];
    int      beats_sent   = 0;
    int      mismatch_cnt = 0;

    // Predictor copy of the timing registers.
    logic [PW_W-1:0] pw_reg = PULSE_WIDTH_RST;
    logic [BI_W-1:0] bi_reg = BIT_INTERVAL_RST;

    // Predictor copy of the transmitter state.
    logic [WORD_W-1:0]  tx_word  = '0;
    logic [NBITS_W-1:0] bits_left = '0;
    logic [BI_W-1:0]    ivl_cnt  = '0;
    logic [PW_W-1:0]    pls_cnt  = '0;
    logic               ivl_run  = 1'b0;
    logic               pls_act  = 1'b0;
    logic               pls_val  = 1'b0;
    logic               tx_busy  = 1'b0;

    wiegand_bit_transmitter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the predicted state by one request and return the line levels.
    function automatic result_t predict_line_result(req_t kind, logic [WORD_W-1:0] word,
                                                    logic [NBITS_W-1:0] nbits);
        result_t     r;
        logic [16:0] next_cnt;
        logic [5:0]  bit_idx;
        logic        fin;
        fin      = 1'b0;
        r.status = ST_OK;
        if (kind == REQ_SEND) begin
            // A rejected send leaves the state alone.
            if (nbits == 0 || nbits > MAX_BITS) begin
                r.status = ST_BAD_LEN;
            end else if (tx_busy) begin
                r.status = ST_BUSY;
            end else begin
                tx_word   = word;
                bits_left = nbits;
                ivl_cnt   = '0;
                pls_cnt   = '0;
                ivl_run   = 1'b1;
                pls_act   = 1'b0;
                pls_val   = 1'b0;
                tx_busy   = 1'b1;
            end
        end else begin
            // Pulse end comes before an interval alarm on the same tick.
            if (pls_act) begin
                pls_cnt = pls_cnt + 8'd1;
                if (pls_cnt >= pw_reg || pls_cnt == 0) begin
                    pls_act = 1'b0;
                    pls_cnt = '0;
                    if (bits_left != 0)
                        bits_left = bits_left - 7'd1;
                    if (bits_left == 0 && tx_busy) begin
                        tx_busy = 1'b0;
                        ivl_run = 1'b0;
                        fin     = 1'b1;
                    end
                end
            end
            if (ivl_run) begin
                next_cnt = {1'b0, ivl_cnt} + 17'd1;
                if (next_cnt >= {1'b0, bi_reg}) begin
                    ivl_cnt = '0;
                    if (bits_left == 0) begin
                        ivl_run = 1'b0;
                    end else begin
                        // Alarm starts, or restarts, the pulse of the current MSB.
                        bit_idx = 6'(bits_left - 7'd1);
                        if (bits_left == 1)
                            ivl_run = 1'b0;
                        pls_cnt = '0;
                        pls_act = 1'b1;
                        pls_val = tx_word[bit_idx];
                    end
                end else begin
                    ivl_cnt = next_cnt[15:0];
                end
            end
        end
        r.line_zero = !(pls_act && !pls_val);
        r.line_one  = !(pls_act && pls_val);
        r.busy_res  = tx_busy;
        r.done_res  = fin;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [NBITS_W-1:0] rand_bad_len();
        return ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
    endfunction

    // Send one request beat. Called and returns at a falling edge; tvalid is
    // left high so that back-to-back beats need no gap.
    task automatic push_beat(req_t kind, logic [WORD_W-1:0] word, logic [NBITS_W-1:0] nbits);
        while (stall_en && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, nbits, word};
        do
            @(posedge aclk);
        while (!s_tready);
        expected_lines.push_back(predict_line_result(kind, word, nbits));
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_tick();
        push_beat(REQ_TICK, rand_word(), 7'($urandom_range(127)));
    endtask

    task automatic send_word(logic [WORD_W-1:0] word, logic [NBITS_W-1:0] nbits);
        push_beat(REQ_SEND, word, nbits);
    endtask

    task automatic tick_until_idle();
        while (tx_busy)
            send_tick();
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_lines.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register write; only issued with no beats in flight.
    task automatic cfg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == REG_PULSE_WIDTH)
            pw_reg = value[PW_W-1:0];
        else
            bi_reg = value[BI_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Ticks right after reset leave both lines high.
    task automatic test_idle_ticks();
        repeat (3) send_tick();
    endtask

    // Lengths of zero and above the maximum are rejected while idle.
    task automatic test_bad_length();
        send_word('1, 7'd0);
        send_word('1, 7'd65);
        send_word('0, 7'd127);
    endtask

    // Zero-width registers act as one tick; also busy and bad sends mid-word.
    task automatic test_fastest_timing();
        wait_for_results();
        cfg_write(REG_PULSE_WIDTH, 16'd0);
        cfg_write(REG_BIT_INTERVAL, 16'd0);
        // Only the low two bits go out: a one, then a zero.
        send_word(64'hFFFF_FFFF_FFFF_FFFE, 7'd2);
        send_word('1, 7'd64);
        send_word('1, 7'd0);
        repeat (4) send_tick();
    endtask

    // An interval shorter than the pulse restarts the same bit; a longer
    // interval written mid-word lets the word finish.
    task automatic test_short_interval();
        wait_for_results();
        cfg_write(REG_PULSE_WIDTH, 16'd3);
        cfg_write(REG_BIT_INTERVAL, 16'd2);
        send_word(64'h1, 7'd2);
        repeat (4) send_tick();
        wait_for_results();
        cfg_write(REG_BIT_INTERVAL, 16'd6);
        tick_until_idle();
        send_tick();
    endtask

    // Widest settings, then limits lowered below a running counter.
    task automatic test_lowered_limits();
        wait_for_results();
        cfg_write(REG_PULSE_WIDTH, 16'h00FF);
        cfg_write(REG_BIT_INTERVAL, 16'd2);
        send_word(64'h0, 7'd1);
        repeat (6) send_tick();
        wait_for_results();
        cfg_write(REG_PULSE_WIDTH, 16'd3);
        tick_until_idle();
        wait_for_results();
        cfg_write(REG_BIT_INTERVAL, 16'hFFFF);
        send_word(64'h1, 7'd1);
        repeat (4) send_tick();
        wait_for_results();
        cfg_write(REG_BIT_INTERVAL, 16'd3);
        tick_until_idle();
        send_tick();
    endtask

    // Mostly complete transmissions, with rejected sends and idle ticks mixed in.
    task automatic run_random_phase(logic [CFG_W-1:0] pw_val, logic [CFG_W-1:0] bi_val,
                                    int beats);
        int stop_at;
        int eff_bi;
        int max_len;
        int len;
        wait_for_results();
        cfg_write(REG_PULSE_WIDTH, pw_val);
        cfg_write(REG_BIT_INTERVAL, bi_val);
        eff_bi  = (bi_val == 0) ? 1 : int'(bi_val);
        max_len = 150 / eff_bi;
        if (max_len < 1)
            max_len = 1;
        if (max_len > MAX_BITS)
            max_len = MAX_BITS;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            case ($urandom_range(9))
                0: begin
                    send_word(rand_word(), rand_bad_len());
                end
                1: begin
                    repeat ($urandom_range(1, 4)) send_tick();
                end
                default: begin
                    len = ($urandom_range(3) == 0) ? max_len : $urandom_range(1, max_len);
                    send_word(rand_word(), 7'(len));
                    while (tx_busy) begin
                        if ($urandom_range(15) == 0)
                            send_word(rand_word(), $urandom_range(1) ?
                                      7'($urandom_range(1, MAX_BITS)) : rand_bad_len());
                        else
                            send_tick();
                    end
                end
            endcase
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int phase;
        int pw;
        stop_at = beats_sent + 1150;
        phase   = 0;
        while (beats_sent < stop_at) begin
            // One phase runs with no stalls at all.
            stall_en = (phase != 2);
            case (phase % 6)
                0: run_random_phase(16'd1, 16'd1, 180);
                1: run_random_phase(16'd0, 16'd0, 180);
                2: run_random_phase(16'd2, 16'd4, 180);
                // Upper bits of the pulse width write are ignored.
                3: run_random_phase(16'hFF07, 16'd9, 180);
                4: run_random_phase(16'd3, 16'd3, 180);
                default: begin
                    pw = $urandom_range(1, 12);
                    run_random_phase(16'(pw), 16'(pw + $urandom_range(0, 10)), 180);
                end
            endcase
            phase++;
        end
        stall_en = 1'b1;
    endtask

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_tready <= !stall_en || ($urandom_range(99) >= 23);
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt < 60)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare every result beat with the oldest prediction.
    always @(posedge aclk) begin : check_lines
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[5:0]);
            if (expected_lines.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt < 60)
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
            end else begin
                want = expected_lines.pop_front();
                check_field("line_zero", want.line_zero, got.line_zero);
                check_field("line_one", want.line_one, got.line_one);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("status", want.status, got.status);
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_ticks();
        test_bad_length();
        test_fastest_timing();
        test_short_interval();
        test_lowered_limits();
        test_random_traffic();
        wait_for_results();
        repeat (10) @(negedge aclk);
        if (mismatch_cnt == 0 && expected_lines.size() == 0)
            $display("wiegand_bit_transmitter_top test passed");
        else
            $display("wiegand_bit_transmitter_top test failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("wiegand_bit_transmitter_top test failed");
        $finish;
    end

endmodule
